/* rtl/ffca_pkg.sv */
// Shared types and constants of the first-fit coalescing allocator.
`default_nettype none
package ffca_pkg;

  localparam int DEF_MAX_ARENAS = 4;
  localparam int DEF_MAX_FREE_EXTENTS = 64;
  localparam int DEF_MAX_LIVE_BLOCKS = 64;

  localparam logic [31:0] ARENA_HDR = 32'd12;
  localparam logic [31:0] BLOCK_HDR = 32'd8;
  localparam logic [30:0] MIN_ARENA_LEN = 31'd20;

  typedef enum logic [1:0] {
    FN_ADD   = 2'd0,
    FN_ALLOC = 2'd1,
    FN_FREE  = 2'd2,
    FN_NOP   = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NO_SPACE  = 3'd1,
    ST_NOT_ALLOC = 3'd2,
    ST_OUTSIDE   = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    SK_ADD,
    SK_ALLOC,
    SK_LIVE,
    SK_NBR,
    SK_FIRST,
    SK_REL
  } scan_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_ADD_SCAN,
    S_ADD_WR,
    S_ALC_SCAN,
    S_ALC_WR,
    S_FR_LIVE,
    S_FR_ARENA,
    S_FR_NBR_GO,
    S_FR_NBR,
    S_FR_MERGE,
    S_FR_FIRST,
    S_FR_CHECK,
    S_FR_REL,
    S_DONE
  } state_t;

  typedef struct packed {
    logic    load;
    logic    scan_start;
    logic    scan_run;
    scan_t   kind;
    logic    add_wr;
    logic    alloc_wr;
    logic    arena_chk;
    logic    merge_wr;
    logic    release_arena;
    logic    set_code;
    status_t code;
    logic    push;
  } cmd_t;

  typedef struct packed {
    func_t func;
    logic  add_short;
    logic  add_full;
    logic  best_found;
    logic  lslot_found;
    logic  li_found;
    logic  ai_found;
    logic  merge_full;
    logic  ai_zero;
    logic  rel_hit;
    logic  scan_done;
    logic  out_free;
  } sts_t;

endpackage
`default_nettype wire

/* rtl/ffca_if.sv */
// Request and response channel interfaces of the allocator.
`default_nettype none
interface ffca_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [31:0] address;
  logic [30:0] length;
  modport source (output valid, func, address, length, input ready);
  modport sink (input valid, func, address, length, output ready);
endinterface

interface ffca_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] result_address;
  logic        arena_released;
  modport source (output valid, status, result_address, arena_released, input ready);
  modport sink (input valid, status, result_address, arena_released, output ready);
endinterface
`default_nettype wire

/* rtl/ffca_ctrl.sv */
// Sequencer that steps each request through its table scans and updates.
`default_nettype none
module ffca_ctrl
  import ffca_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.kind = SK_ADD;
    cmd.code = ST_OK;
    req_ready = (state == S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (sts.func)
          FN_ADD: begin
            if (sts.add_short) begin
              cmd.set_code = 1'b1;
              cmd.code = ST_NO_SPACE;
              state_next = S_DONE;
            end else begin
              cmd.scan_start = 1'b1;
              cmd.kind = SK_ADD;
              state_next = S_ADD_SCAN;
            end
          end
          FN_ALLOC: begin
            cmd.scan_start = 1'b1;
            cmd.kind = SK_ALLOC;
            state_next = S_ALC_SCAN;
          end
          FN_FREE: begin
            cmd.scan_start = 1'b1;
            cmd.kind = SK_LIVE;
            state_next = S_FR_LIVE;
          end
          default: begin
            cmd.set_code = 1'b1;
            cmd.code = ST_OK;
            state_next = S_DONE;
          end
        endcase
      end
      S_ADD_SCAN: begin
        cmd.scan_run = 1'b1;
        if (sts.scan_done) state_next = S_ADD_WR;
      end
      S_ADD_WR: begin
        cmd.set_code = 1'b1;
        if (sts.add_full) begin
          cmd.code = ST_FULL;
        end else begin
          cmd.add_wr = 1'b1;
        end
        state_next = S_DONE;
      end
      S_ALC_SCAN: begin
        cmd.scan_run = 1'b1;
        if (sts.scan_done) state_next = S_ALC_WR;
      end
      S_ALC_WR: begin
        cmd.set_code = 1'b1;
        if (!sts.best_found) begin
          cmd.code = ST_NO_SPACE;
        end else if (!sts.lslot_found) begin
          cmd.code = ST_FULL;
        end else begin
          cmd.alloc_wr = 1'b1;
        end
        state_next = S_DONE;
      end
      S_FR_LIVE: begin
        cmd.scan_run = 1'b1;
        if (sts.scan_done) state_next = S_FR_ARENA;
      end
      S_FR_ARENA: begin
        if (!sts.li_found) begin
          cmd.set_code = 1'b1;
          cmd.code = ST_NOT_ALLOC;
          state_next = S_DONE;
        end else begin
          cmd.arena_chk = 1'b1;
          state_next = S_FR_NBR_GO;
        end
      end
      S_FR_NBR_GO: begin
        if (!sts.ai_found) begin
          cmd.set_code = 1'b1;
          cmd.code = ST_OUTSIDE;
          state_next = S_DONE;
        end else begin
          cmd.scan_start = 1'b1;
          cmd.kind = SK_NBR;
          state_next = S_FR_NBR;
        end
      end
      S_FR_NBR: begin
        cmd.scan_run = 1'b1;
        if (sts.scan_done) state_next = S_FR_MERGE;
      end
      S_FR_MERGE: begin
        cmd.set_code = 1'b1;
        if (sts.merge_full) begin
          cmd.code = ST_FULL;
          state_next = S_DONE;
        end else begin
          cmd.merge_wr = 1'b1;
          if (sts.ai_zero) begin
            state_next = S_DONE;
          end else begin
            cmd.scan_start = 1'b1;
            cmd.kind = SK_FIRST;
            state_next = S_FR_FIRST;
          end
        end
      end
      S_FR_FIRST: begin
        cmd.scan_run = 1'b1;
        if (sts.scan_done) state_next = S_FR_CHECK;
      end
      S_FR_CHECK: begin
        if (sts.rel_hit) begin
          cmd.release_arena = 1'b1;
          cmd.scan_start = 1'b1;
          cmd.kind = SK_REL;
          state_next = S_FR_REL;
        end else begin
          state_next = S_DONE;
        end
      end
      S_FR_REL: begin
        cmd.scan_run = 1'b1;
        if (sts.scan_done) state_next = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.push = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

/* rtl/ffca_dp.sv */
// Datapath with arena registers, extent and live-block tables, scan unit and result word.
`default_nettype none
module ffca_dp
  import ffca_pkg::*;
#(
  parameter int MAX_ARENAS = DEF_MAX_ARENAS,
  parameter int MAX_FREE_EXTENTS = DEF_MAX_FREE_EXTENTS,
  parameter int MAX_LIVE_BLOCKS = DEF_MAX_LIVE_BLOCKS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [1:0]  req_func,
  input  wire logic [31:0] req_address,
  input  wire logic [30:0] req_length,
  input  wire cmd_t        cmd,
  output sts_t             sts,
  output logic             rsp_valid,
  input  wire logic        rsp_ready,
  output logic [2:0]       rsp_status,
  output logic [31:0]      rsp_result_address,
  output logic             rsp_arena_released
);

  localparam int EW = $clog2(MAX_FREE_EXTENTS);
  localparam int LW = $clog2(MAX_LIVE_BLOCKS);
  localparam int AW = (MAX_ARENAS > 1) ? $clog2(MAX_ARENAS) : 1;
  localparam int NW = $clog2(MAX_ARENAS + 1);
  localparam int SMAX = (MAX_FREE_EXTENTS > MAX_LIVE_BLOCKS) ? MAX_FREE_EXTENTS :
                        MAX_LIVE_BLOCKS;
  localparam int CW = $clog2(SMAX + 1);

  // Request registers.
  logic [1:0]  func_r;
  logic [31:0] addr_r;
  logic [30:0] len_r;
  logic [31:0] size_rnd;
  logic [31:0] size_sum;
  logic [32:0] need;
  logic [31:0] fb;

  // Arena registers.
  logic [31:0] arena_base [MAX_ARENAS];
  logic [31:0] arena_span [MAX_ARENAS];
  logic [NW-1:0] num_ar;

  // Tables.
  logic [31:0] ext_start [MAX_FREE_EXTENTS];
  logic [31:0] ext_size [MAX_FREE_EXTENTS];
  logic [AW-1:0] ext_owner [MAX_FREE_EXTENTS];
  logic [MAX_FREE_EXTENTS-1:0] ext_valid;
  logic [31:0] live_start [MAX_LIVE_BLOCKS];
  logic [31:0] live_size [MAX_LIVE_BLOCKS];
  logic [MAX_LIVE_BLOCKS-1:0] live_valid;

  // Scan unit.
  scan_t skind;
  logic [CW-1:0] cnt, lim, pidx;
  logic pv;
  logic [31:0] e_start_q, e_size_q, l_start_q, l_size_q;
  logic [AW-1:0] e_own_q;
  logic [EW-1:0] ei;
  logic [LW-1:0] lj;
  logic e_in, l_in, ev_p, lv_p, issue;

  // Scan results.
  logic fslot_found, lslot_found, best_found, li_found, pb_found, nb_found, first_found;
  logic [EW-1:0] fslot, best_idx, pb_idx, nb_idx;
  logic [LW-1:0] lslot, li_idx;
  logic [AW-1:0] best_own;
  logic [31:0] best_start, best_size, li_size, pb_start, pb_size, nb_start, nb_size;
  logic [31:0] first_start, first_size;
  logic ai_found;
  logic [AW-1:0] ai;

  // Arena check and merge logic.
  logic chk_found;
  logic [AW-1:0] chk_idx;
  logic back, fwd;
  logic [31:0] mstart, msize, back_size, fwd_size;

  // Table write ports.
  logic es_we, ez_we, eo_we;
  logic [EW-1:0] e_wa;
  logic [31:0] es_wd, ez_wd;
  logic [AW-1:0] eo_wd;

  // Result registers.
  status_t res_code;
  logic [31:0] res_addr;
  logic res_rel;

  function automatic logic [31:0] req_addr_plus_hdr(input logic [31:0] a);
    return a + ARENA_HDR;
  endfunction

  assign size_sum = {1'b0, len_r} + 32'd1;
  assign size_rnd = {size_sum[31:1], 1'b0};
  assign need = {1'b0, size_rnd} + {1'b0, BLOCK_HDR};
  assign fb = addr_r - BLOCK_HDR;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= req_func;
      addr_r <= req_address;
      len_r <= req_length;
    end
  end

  // Scan sequencing: address issue, a registered table read, then evaluation.
  assign issue = cmd.scan_run && (cnt < lim);
  assign ei = pidx[EW-1:0];
  assign lj = pidx[LW-1:0];
  assign e_in = pidx < CW'(MAX_FREE_EXTENTS);
  assign l_in = pidx < CW'(MAX_LIVE_BLOCKS);
  assign ev_p = e_in && ext_valid[ei];
  assign lv_p = l_in && live_valid[lj];

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
      cnt <= '0;
      lim <= '0;
      skind <= SK_ADD;
    end else if (cmd.scan_start) begin
      pv <= 1'b0;
      cnt <= '0;
      skind <= cmd.kind;
      if (cmd.kind == SK_LIVE) begin
        lim <= CW'(MAX_LIVE_BLOCKS);
      end else if (cmd.kind == SK_ALLOC) begin
        lim <= CW'(SMAX);
      end else begin
        lim <= CW'(MAX_FREE_EXTENTS);
      end
    end else begin
      pv <= issue;
      if (issue) begin
        cnt <= cnt + 1'b1;
        pidx <= cnt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (es_we) ext_start[e_wa] <= es_wd;
    e_start_q <= ext_start[cnt[EW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (ez_we) ext_size[e_wa] <= ez_wd;
    e_size_q <= ext_size[cnt[EW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (eo_we) ext_owner[e_wa] <= eo_wd;
    e_own_q <= ext_owner[cnt[EW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.alloc_wr) begin
      live_start[lslot] <= best_start + BLOCK_HDR;
      live_size[lslot] <= size_rnd;
    end
    l_start_q <= live_start[cnt[LW-1:0]];
    l_size_q <= live_size[cnt[LW-1:0]];
  end

  // Evaluation of one table entry per cycle.
  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      fslot_found <= 1'b0;
      lslot_found <= 1'b0;
      best_found <= 1'b0;
      li_found <= 1'b0;
      pb_found <= 1'b0;
      nb_found <= 1'b0;
      first_found <= 1'b0;
    end else if (pv) begin
      if (e_in && !ext_valid[ei] && !fslot_found) begin
        fslot_found <= 1'b1;
        fslot <= ei;
      end
      unique case (skind)
        SK_ALLOC: begin
          if (ev_p && ({1'b0, e_size_q} >= need) &&
              (!best_found || e_own_q < best_own ||
               (e_own_q == best_own && e_start_q < best_start))) begin
            best_found <= 1'b1;
            best_idx <= ei;
            best_own <= e_own_q;
            best_start <= e_start_q;
            best_size <= e_size_q;
          end
          if (l_in && !live_valid[lj] && !lslot_found) begin
            lslot_found <= 1'b1;
            lslot <= lj;
          end
        end
        SK_LIVE: begin
          if (lv_p && l_start_q == addr_r && !li_found) begin
            li_found <= 1'b1;
            li_idx <= lj;
            li_size <= l_size_q;
          end
        end
        SK_NBR: begin
          if (ev_p && e_own_q == ai) begin
            if (e_start_q < fb) begin
              if (!pb_found || e_start_q > pb_start) begin
                pb_found <= 1'b1;
                pb_idx <= ei;
                pb_start <= e_start_q;
                pb_size <= e_size_q;
              end
            end else if (!nb_found || e_start_q < nb_start) begin
              nb_found <= 1'b1;
              nb_idx <= ei;
              nb_start <= e_start_q;
              nb_size <= e_size_q;
            end
          end
        end
        SK_FIRST: begin
          if (ev_p && e_own_q == ai && (!first_found || e_start_q < first_start)) begin
            first_found <= 1'b1;
            first_start <= e_start_q;
            first_size <= e_size_q;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Arena containment of the freed block header, lowest arena first.
  always_comb begin
    logic [32:0] lo;
    logic [33:0] hi;
    chk_found = 1'b0;
    chk_idx = '0;
    for (int a = MAX_ARENAS - 1; a >= 0; a--) begin
      lo = {1'b0, arena_base[a]} + {1'b0, ARENA_HDR};
      hi = {1'b0, lo} + {2'b0, arena_span[a]};
      if (NW'(a) < num_ar && {1'b0, fb} >= lo && {2'b0, fb} < hi) begin
        chk_found = 1'b1;
        chk_idx = AW'(a);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.arena_chk) begin
      ai_found <= chk_found;
      ai <= chk_idx;
    end
  end

  assign back = pb_found && (pb_start + BLOCK_HDR + pb_size == fb);
  assign mstart = back ? pb_start : fb;
  assign msize = back ? pb_size + BLOCK_HDR + li_size : li_size;
  assign fwd = nb_found && (mstart + BLOCK_HDR + msize == nb_start);
  assign back_size = fwd ? msize + BLOCK_HDR + nb_size : msize;
  assign fwd_size = li_size + BLOCK_HDR + nb_size;

  // Extent table write port.
  always_comb begin
    es_we = 1'b0;
    ez_we = 1'b0;
    eo_we = 1'b0;
    e_wa = fslot;
    es_wd = fb;
    ez_wd = li_size;
    eo_wd = ai;
    if (cmd.add_wr) begin
      es_we = 1'b1;
      ez_we = 1'b1;
      eo_we = 1'b1;
      es_wd = req_addr_plus_hdr(addr_r);
      ez_wd = {1'b0, len_r} - ARENA_HDR - BLOCK_HDR;
      eo_wd = num_ar[AW-1:0];
    end else if (cmd.alloc_wr) begin
      es_we = 1'b1;
      ez_we = 1'b1;
      e_wa = best_idx;
      es_wd = best_start + BLOCK_HDR + size_rnd;
      ez_wd = best_size - need[31:0];
    end else if (cmd.merge_wr) begin
      if (back) begin
        ez_we = 1'b1;
        e_wa = pb_idx;
        ez_wd = back_size;
      end else if (fwd) begin
        es_we = 1'b1;
        ez_we = 1'b1;
        e_wa = nb_idx;
        ez_wd = fwd_size;
      end else begin
        es_we = 1'b1;
        ez_we = 1'b1;
        eo_we = 1'b1;
      end
    end else if (pv && skind == SK_REL && ev_p && e_own_q > ai) begin
      eo_we = 1'b1;
      e_wa = ei;
      eo_wd = e_own_q - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ext_valid <= '0;
      live_valid <= '0;
    end else begin
      if (cmd.add_wr) ext_valid[fslot] <= 1'b1;
      if (cmd.alloc_wr) live_valid[lslot] <= 1'b1;
      if (cmd.merge_wr) begin
        live_valid[li_idx] <= 1'b0;
        if (back && fwd) ext_valid[nb_idx] <= 1'b0;
        if (!back && !fwd) ext_valid[fslot] <= 1'b1;
      end
      if (pv && skind == SK_REL && ev_p && e_own_q == ai) ext_valid[ei] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_ar <= '0;
    end else if (cmd.add_wr) begin
      num_ar <= num_ar + 1'b1;
    end else if (cmd.release_arena) begin
      num_ar <= num_ar - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.add_wr) begin
      arena_base[num_ar[AW-1:0]] <= addr_r;
      arena_span[num_ar[AW-1:0]] <= {1'b0, len_r} - ARENA_HDR;
    end else if (cmd.release_arena) begin
      for (int a = 0; a < MAX_ARENAS - 1; a++) begin
        if (AW'(a) >= ai && NW'(a + 1) < num_ar) begin
          arena_base[a] <= arena_base[a + 1];
          arena_span[a] <= arena_span[a + 1];
        end
      end
    end
  end

  // Result word and output register.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_addr <= '0;
      res_rel <= 1'b0;
    end else if (cmd.alloc_wr) begin
      res_addr <= best_start + BLOCK_HDR;
    end else if (cmd.release_arena) begin
      res_addr <= arena_base[ai];
      res_rel <= 1'b1;
    end
    if (cmd.set_code) res_code <= cmd.code;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.push) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      rsp_status <= res_code;
      rsp_result_address <= res_addr;
      rsp_arena_released <= res_rel;
    end
  end

  always_comb begin
    sts.func = func_t'(func_r);
    sts.add_short = len_r < MIN_ARENA_LEN;
    sts.add_full = (num_ar >= NW'(MAX_ARENAS)) || !fslot_found;
    sts.best_found = best_found;
    sts.lslot_found = lslot_found;
    sts.li_found = li_found;
    sts.ai_found = ai_found;
    sts.merge_full = !back && !fwd && !fslot_found;
    sts.ai_zero = (ai == '0);
    sts.rel_hit = first_found && (first_start == arena_base[ai] + ARENA_HDR) &&
                  (first_size + BLOCK_HDR == arena_span[ai]);
    sts.scan_done = (cnt == lim) && !pv;
    sts.out_free = !rsp_valid || rsp_ready;
  end

endmodule
`default_nettype wire

/* rtl/first_fit_coalescing_allocator.sv */
// Top level of the first-fit coalescing allocator.
//
//   Channel | Direction | Word fields
//   req     | in        | func, address, length
//   rsp     | out       | status, result_address, arena_released
//
// One request at a time; each table scan reads one entry per cycle from its table memory.
// Add scans the extent table and allocate scans both tables. Free runs a live-block lookup
// and neighbor scan, then for arenas other than the first an emptiness scan and, if the
// arena is empty, a release sweep.
// rst is synchronous and clears all valid bits, the arena count and the response valid flag.
// A new request is taken while a response still waits; completion stalls until it is taken.
`default_nettype none
module first_fit_coalescing_allocator
  import ffca_pkg::*;
#(
  parameter int MAX_ARENAS = DEF_MAX_ARENAS,
  parameter int MAX_FREE_EXTENTS = DEF_MAX_FREE_EXTENTS,
  parameter int MAX_LIVE_BLOCKS = DEF_MAX_LIVE_BLOCKS
) (
  input wire logic clk,
  input wire logic rst,
  ffca_req_if.sink req,
  ffca_rsp_if.source rsp
);

  cmd_t cmd;
  sts_t sts;

  ffca_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ffca_dp #(
    .MAX_ARENAS       (MAX_ARENAS),
    .MAX_FREE_EXTENTS (MAX_FREE_EXTENTS),
    .MAX_LIVE_BLOCKS  (MAX_LIVE_BLOCKS)
  ) u_dp (
    .clk                (clk),
    .rst                (rst),
    .req_func           (req.func),
    .req_address        (req.address),
    .req_length         (req.length),
    .cmd                (cmd),
    .sts                (sts),
    .rsp_valid          (rsp.valid),
    .rsp_ready          (rsp.ready),
    .rsp_status         (rsp.status),
    .rsp_result_address (rsp.result_address),
    .rsp_arena_released (rsp.arena_released)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request taken while another is in progress");

  a_release_ok: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.arena_released) |-> (rsp.status == ST_OK))
    else $error("arena release reported with an error status");

  a_error_no_addr: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status != ST_OK) |-> (rsp.result_address == 32'd0))
    else $error("error response carries an address");

endmodule
`default_nettype wire
